// File: rtl/buzzer_tone_sequencer_core_assert.svh
// Assertion macros shared by the buzzer tone sequencer modules.
`ifndef BUZZER_TONE_SEQUENCER_CORE_ASSERT_SVH
`define BUZZER_TONE_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BTS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("buzzer tone sequencer: same-cycle check failed");

// Next-cycle implication.
`define BTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("buzzer tone sequencer: next-cycle check failed");

`endif

// File: rtl/bts_pkg.sv
// Types, codes and the tone ROM of the buzzer tone sequencer.
`timescale 1ns / 1ps
package bts_pkg;

  localparam int SEQ_COUNT  = 21;
  localparam int MAX_NOTES  = 7;
  localparam int REACTIONS  = 6;
  localparam int REACT_BASE = 3;

  typedef logic [4:0]  seq_sel_t;
  typedef logic [2:0]  note_pos_t;
  typedef logic [11:0] freq_t;
  typedef logic [7:0]  dur_t;

  // Request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;

  // Buzzer commands
  localparam logic [1:0] CMD_NONE    = 2'd0;
  localparam logic [1:0] CMD_SILENCE = 2'd1;
  localparam logic [1:0] CMD_TONE    = 2'd2;

  // Sound identifiers
  localparam logic [3:0] SND_NONE          = 4'd0;
  localparam logic [3:0] SND_LAST_REACTION = 4'd6;
  localparam logic [3:0] SND_BOOT          = 4'd7;
  localparam logic [3:0] SND_WAKE          = 4'd9;

  localparam logic [1:0] NO_VARIANT = 2'd3;

  typedef struct packed {
    logic [1:0] buzzer_cmd;
    freq_t      tone_freq;
    logic       engine_active;
    logic [1:0] variant_chosen;
  } bts_result_t;

  localparam freq_t NOTE_ROM [SEQ_COUNT][MAX_NOTES] = '{
    '{880, 1320, 1760, 0, 0, 0, 0},
    '{700, 560, 420, 0, 0, 0, 0},
    '{660, 980, 1480, 0, 0, 0, 0},
    '{988, 1319, 1175, 1760, 1480, 1047, 1568},
    '{784, 1175, 988, 1397, 1760, 0, 0},
    '{1047, 1319, 1568, 2093, 1760, 2349, 0},
    '{740, 988, 1245, 1109, 0, 0, 0},
    '{932, 1175, 1047, 1397, 1245, 0, 0},
    '{659, 880, 1109, 988, 1319, 0, 0},
    '{784, 698, 587, 523, 0, 0, 0},
    '{659, 622, 659, 554, 494, 0, 0},
    '{740, 740, 622, 523, 0, 0, 0},
    '{2093, 784, 1568, 659, 0, 0, 0},
    '{2349, 988, 1976, 1175, 2217, 0, 0},
    '{1760, 2637, 1319, 2093, 0, 0, 0},
    '{740, 554, 0, 0, 0, 0, 0},
    '{659, 659, 494, 0, 0, 0, 0},
    '{587, 466, 622, 0, 0, 0, 0},
    '{880, 1397, 740, 1047, 0, 0, 0},
    '{1047, 784, 1319, 698, 988, 0, 0},
    '{932, 1480, 1175, 659, 0, 0, 0}
  };

  localparam dur_t DUR_ROM [SEQ_COUNT][MAX_NOTES] = '{
    '{60, 60, 90, 0, 0, 0, 0},
    '{80, 90, 110, 0, 0, 0, 0},
    '{60, 60, 90, 0, 0, 0, 0},
    '{65, 55, 55, 75, 65, 55, 85},
    '{70, 65, 60, 70, 100, 0, 0},
    '{45, 45, 50, 65, 50, 90, 0},
    '{75, 80, 105, 130, 0, 0, 0},
    '{65, 75, 85, 100, 125, 0, 0},
    '{70, 70, 90, 90, 135, 0, 0},
    '{80, 85, 95, 125, 0, 0, 0},
    '{65, 65, 75, 90, 130, 0, 0},
    '{55, 70, 85, 145, 0, 0, 0},
    '{55, 80, 50, 110, 0, 0, 0},
    '{40, 65, 40, 60, 85, 0, 0},
    '{45, 50, 70, 95, 0, 0, 0},
    '{120, 210, 0, 0, 0, 0, 0},
    '{80, 90, 190, 0, 0, 0, 0},
    '{110, 140, 180, 0, 0, 0, 0},
    '{85, 70, 135, 120, 0, 0, 0},
    '{65, 90, 75, 125, 105, 0, 0},
    '{90, 65, 80, 155, 0, 0, 0}
  };

  localparam note_pos_t COUNT_ROM [SEQ_COUNT] = '{
    3, 3, 3, 7, 5, 6, 4, 5, 5, 4, 5, 4, 4, 5, 4, 2, 3, 3, 4, 5, 4
  };

  localparam dur_t GAP_ROM [SEQ_COUNT] = '{
    20, 24, 20, 18, 22, 16, 24, 20, 22, 24, 18, 20, 15, 12, 14, 90, 65, 75, 38, 30, 42
  };

  // Out-of-range rows fall back to the first sequence.
  function automatic seq_sel_t clamp_row(input seq_sel_t sel);
    clamp_row = (sel < seq_sel_t'(SEQ_COUNT)) ? sel : '0;
  endfunction

  // A position past the table reads as zero.
  function automatic freq_t note_freq(input seq_sel_t row, input note_pos_t pos);
    note_freq = (pos < note_pos_t'(MAX_NOTES)) ? NOTE_ROM[row][pos] : '0;
  endfunction

  function automatic dur_t note_dur(input seq_sel_t row, input note_pos_t pos);
    note_dur = (pos < note_pos_t'(MAX_NOTES)) ? DUR_ROM[row][pos] : '0;
  endfunction

endpackage

// File: rtl/bts_if.sv
// Request and result channel interfaces of the buzzer tone sequencer.
`timescale 1ns / 1ps
interface bts_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] now_ms;
  logic        reaction_generic;
  logic [3:0]  sound_id;
  logic [1:0]  rand_first;
  logic        rand_step;

  modport source (output valid, req_type, now_ms, reaction_generic, sound_id,
                  rand_first, rand_step, input ready);
  modport sink (input valid, req_type, now_ms, reaction_generic, sound_id,
                rand_first, rand_step, output ready);
endinterface

interface bts_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  buzzer_cmd;
  logic [11:0] tone_freq;
  logic        engine_active;
  logic [1:0]  variant_chosen;

  modport source (output valid, buzzer_cmd, tone_freq, engine_active, variant_chosen,
                  input ready);
  modport sink (input valid, buzzer_cmd, tone_freq, engine_active, variant_chosen,
                output ready);
endinterface

// File: rtl/buzzer_tone_sequencer_core.sv
// Buzzer tone sequencer: tick-driven note/gap stepping over a tone ROM.
//
// Usage:
//   request channel: one beat per event (tick, start sound, stop reaction).
//     Ticks carry the current millisecond time; the block compares it against
//     the phase deadline modulo 2^TIME_BITS, so clock wraparound is harmless.
//   result channel: exactly one beat per request beat, in order, carrying the
//     buzzer command, the tone frequency, whether a sequence is still running
//     and the reaction variant that a start picked.
//   Buffering: each result is registered, into the skid while output stalls.
//   Throughput: one request per cycle while request.ready is high. The event
//     decision is one time subtract/compare, one ROM read and one add, all
//     between the sequencer state registers and the result register.
//   Stall: results queue in a two-entry buffer (output register plus skid);
//     request.ready drops only once both entries are full, and rises again
//     the cycle after the receiver takes a beat.
//   Reset (rst, synchronous): no sequence selected, deadline and note
//     position cleared, the remembered variant of every reaction set to none,
//     result buffer empty.
`timescale 1ns / 1ps
`include "buzzer_tone_sequencer_core_assert.svh"
module buzzer_tone_sequencer_core
  import bts_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  bts_req_if.sink   request,
  bts_res_if.source result
);

  typedef logic [TIME_BITS-1:0] time_t;

  // sequencer state
  logic [3:0] active_kind;
  seq_sel_t   sequence_select;
  time_t      phase_deadline;
  note_pos_t  note_position;
  logic       note_sounding;
  logic [1:0] previous_variant [REACTIONS];

  logic [3:0] active_kind_next;
  seq_sel_t   sequence_select_next;
  time_t      phase_deadline_next;
  note_pos_t  note_position_next;
  logic       note_sounding_next;

  logic        accept;
  logic        room;
  time_t       now_t;
  time_t       elapsed;
  seq_sel_t    row;
  logic        is_reaction;
  logic        var_write;
  logic [2:0]  var_slot;
  logic [1:0]  var_value;
  bts_result_t res;

  assign accept        = request.valid & room;
  assign request.ready = room;

  generate
    if (TIME_BITS <= 32) begin : g_time_narrow
      assign now_t = request.now_ms[TIME_BITS-1:0];
    end else begin : g_time_wide
      assign now_t = {{(TIME_BITS-32){1'b0}}, request.now_ms};
    end
  endgenerate

  assign elapsed     = now_t - phase_deadline;
  assign row         = clamp_row(sequence_select);
  assign is_reaction = (active_kind != SND_NONE) && (active_kind <= SND_LAST_REACTION);

  // Decide the event: next state and the result beat.
  always_comb begin
    logic [1:0] first;
    logic [2:0] bumped;
    logic [1:0] pick;
    logic       do_halt;

    active_kind_next     = active_kind;
    sequence_select_next = sequence_select;
    phase_deadline_next  = phase_deadline;
    note_position_next   = note_position;
    note_sounding_next   = note_sounding;
    var_write            = 1'b0;
    var_slot             = 3'(request.sound_id - 4'd1);
    var_value            = NO_VARIANT;
    res.buzzer_cmd       = CMD_NONE;
    res.tone_freq        = '0;
    res.variant_chosen   = NO_VARIANT;
    do_halt              = 1'b0;

    // variant draw: reduce modulo three, step past a repeat
    first  = (request.rand_first == 2'd3) ? 2'd0 : request.rand_first;
    bumped = {1'b0, first} + 3'd1 + {2'b00, request.rand_step};
    if (bumped >= 3'd3) begin
      bumped = bumped - 3'd3;
    end
    pick = (var_slot < 3'(REACTIONS) && first == previous_variant[var_slot])
           ? bumped[1:0] : first;

    case (request.req_type)
      REQ_TICK: begin
        if (is_reaction && !request.reaction_generic) begin
          do_halt        = 1'b1;
          res.buzzer_cmd = CMD_SILENCE;
        end else if (active_kind != SND_NONE && !elapsed[TIME_BITS-1]) begin
          if (note_sounding) begin
            // end the note, start the gap
            note_sounding_next  = 1'b0;
            phase_deadline_next = now_t + time_t'(GAP_ROM[row]);
            res.buzzer_cmd      = CMD_SILENCE;
          end else if (note_position >= COUNT_ROM[row]) begin
            do_halt        = 1'b1;
            res.buzzer_cmd = CMD_SILENCE;
          end else begin
            // start the next note
            res.tone_freq       = note_freq(row, note_position);
            phase_deadline_next = now_t + time_t'(note_dur(row, note_position));
            note_sounding_next  = 1'b1;
            note_position_next  = note_position + 3'd1;
            res.buzzer_cmd      = CMD_TONE;
          end
        end
      end
      REQ_START: begin
        if (request.sound_id == SND_NONE) begin
          if (is_reaction) begin
            do_halt        = 1'b1;
            res.buzzer_cmd = CMD_SILENCE;
          end
        end else if (request.sound_id <= SND_WAKE) begin
          active_kind_next    = request.sound_id;
          phase_deadline_next = now_t;
          note_position_next  = '0;
          note_sounding_next  = 1'b0;
          res.buzzer_cmd      = CMD_SILENCE;
          if (request.sound_id <= SND_LAST_REACTION) begin
            var_write            = 1'b1;
            var_value            = pick;
            res.variant_chosen   = pick;
            sequence_select_next = seq_sel_t'(REACT_BASE) + seq_sel_t'(var_slot) * 5'd3
                                   + seq_sel_t'(pick);
          end else begin
            sequence_select_next = seq_sel_t'(request.sound_id - SND_BOOT);
          end
        end
      end
      REQ_STOP: begin
        if (is_reaction) begin
          do_halt        = 1'b1;
          res.buzzer_cmd = CMD_SILENCE;
        end
      end
      default: begin
      end
    endcase

    if (do_halt) begin
      active_kind_next     = SND_NONE;
      sequence_select_next = '0;
      phase_deadline_next  = '0;
      note_position_next   = '0;
      note_sounding_next   = 1'b0;
    end

    res.engine_active = (active_kind_next != SND_NONE);
  end

  // Advance state on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_kind     <= SND_NONE;
      sequence_select <= '0;
      phase_deadline  <= '0;
      note_position   <= '0;
      note_sounding   <= 1'b0;
      for (int i = 0; i < REACTIONS; i++) begin
        previous_variant[i] <= NO_VARIANT;
      end
    end else if (accept) begin
      active_kind     <= active_kind_next;
      sequence_select <= sequence_select_next;
      phase_deadline  <= phase_deadline_next;
      note_position   <= note_position_next;
      note_sounding   <= note_sounding_next;
      if (var_write) begin
        previous_variant[var_slot] <= var_value;
      end
    end
  end

  bts_obuf u_obuf (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .data   (res),
    .room   (room),
    .result (result)
  );

  `BTS_ASSERT_NOW(a_sounding_needs_seq, clk, rst, note_sounding, active_kind != SND_NONE)
  `BTS_ASSERT_NOW(a_idle_is_cleared, clk, rst, active_kind == SND_NONE,
                  phase_deadline == '0 && note_position == '0 && sequence_select == '0)
  `BTS_ASSERT_NOW(a_select_in_rom, clk, rst, 1'b1, sequence_select < seq_sel_t'(SEQ_COUNT))
  `BTS_ASSERT_NEXT(a_accept_gives_result, clk, rst, accept, result.valid)

endmodule

// File: rtl/bts_obuf.sv
// Two-entry result buffer: output register plus skid register.
`timescale 1ns / 1ps
`include "buzzer_tone_sequencer_core_assert.svh"
module bts_obuf
  import bts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  bts_result_t data,
  output logic        room,
  bts_res_if.source   result
);

  logic        out_valid;
  bts_result_t out_data;
  logic        skid_valid;
  bts_result_t skid_data;
  logic        pop;

  assign pop  = out_valid & result.ready;
  assign room = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      // output slot frees up: refill from skid first, then from the new beat
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= load;
        if (load) begin
          out_data <= data;
        end
      end
    end else if (load) begin
      // output stalled: park the beat
      skid_valid <= 1'b1;
      skid_data  <= data;
    end
  end

  assign result.valid          = out_valid;
  assign result.buzzer_cmd     = out_data.buzzer_cmd;
  assign result.tone_freq      = out_data.tone_freq;
  assign result.engine_active  = out_data.engine_active;
  assign result.variant_chosen = out_data.variant_chosen;

  `BTS_ASSERT_NOW(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `BTS_ASSERT_NEXT(a_out_held, clk, rst, out_valid && !pop, out_valid)
  `BTS_ASSERT_NEXT(a_skid_drains, clk, rst, pop && skid_valid, out_valid && !skid_valid)

endmodule
